// ===== rtl/core/telnet_option_negotiator_assert.svh =====
// ----------------------------------------------------------------------------
// Telnet option negotiator assertion macros
// Shorthand for the clocked checks written at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TELNET_OPTION_NEGOTIATOR_ASSERT_SVH
`define TELNET_OPTION_NEGOTIATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TON_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("telnet negotiator check failed");

// The consequent must hold in the cycle after the antecedent.
`define TON_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("telnet negotiator check failed");

`endif

// ===== rtl/core/ton_pkg.sv =====
// ----------------------------------------------------------------------------
// Telnet option negotiator package
// Protocol codes, negotiation states, reply job descriptor and the fixed
// terminal-type reply table used by the emitter.
// ----------------------------------------------------------------------------
package ton_pkg;

    // Telnet command bytes.
    localparam logic [7:0] C_IAC  = 8'd255;
    localparam logic [7:0] C_DONT = 8'd254;
    localparam logic [7:0] C_DO   = 8'd253;
    localparam logic [7:0] C_WONT = 8'd252;
    localparam logic [7:0] C_WILL = 8'd251;
    localparam logic [7:0] C_SB   = 8'd250;
    localparam logic [7:0] C_SE   = 8'd240;

    // Option codes and subnegotiation qualifiers.
    localparam logic [7:0] OPT_TTYPE = 8'd24;
    localparam logic [7:0] OPT_NAWS  = 8'd31;
    localparam logic [7:0] OPT_SGA   = 8'd3;
    localparam logic [7:0] OPT_ECHO  = 8'd1;
    localparam logic [7:0] Q_SEND    = 8'd1;
    localparam logic [7:0] Q_IS      = 8'd0;

    // Reply sequencing: index width and the last index of each reply kind.
    localparam int unsigned IDX_W = 4;
    localparam logic [IDX_W-1:0] DATA_LAST   = 4'd0;
    localparam logic [IDX_W-1:0] REPLY3_LAST = 4'd2;
    localparam logic [IDX_W-1:0] TTYPE_LAST  = 4'd10;

    // Negotiation state.
    typedef enum logic [3:0] {
        ST_DATA    = 4'd0,
        ST_IAC     = 4'd1,
        ST_DO      = 4'd2,
        ST_DONT    = 4'd3,
        ST_WILL    = 4'd4,
        ST_WONT    = 4'd5,
        ST_SBSTART = 4'd6,
        ST_SBIAC   = 4'd7,
        ST_SBBODY  = 4'd8,
        ST_SBTTYPE = 4'd9
    } neg_state_t;

    // Kind of result burst one input item causes.
    typedef enum logic [1:0] {
        JOB_DATA   = 2'd0,
        JOB_REPLY3 = 2'd1,
        JOB_TTYPE  = 2'd2
    } job_kind_t;

    // Burst descriptor handed from the decoder to the emitter.
    // For a data job, verb carries the data byte.
    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] verb;
        logic [7:0] opt;
        logic       flag;
    } job_t;

    // Terminal-type reply: IAC SB TTYPE IS "vt100" IAC SE.
    function automatic logic [7:0] ttype_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = C_IAC;
            4'd1:    b = C_SB;
            4'd2:    b = OPT_TTYPE;
            4'd3:    b = Q_IS;
            4'd4:    b = 8'h76;
            4'd5:    b = 8'h74;
            4'd6:    b = 8'h31;
            4'd7:    b = 8'h30;
            4'd8:    b = 8'h30;
            4'd9:    b = C_IAC;
            4'd10:   b = C_SE;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/ton_decoder.sv =====
// ----------------------------------------------------------------------------
// Telnet negotiation decoder
// Holds the negotiation state and turns each accepted item into an optional
// result burst descriptor for the emitter.
// ----------------------------------------------------------------------------
module ton_decoder (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic [7:0]    rx_byte,
    output logic          job_load,
    output ton_pkg::job_t job
);

    ton_pkg::neg_state_t state_reg;
    ton_pkg::neg_state_t state_next;
    logic                has_job;

    // State register, advanced on every accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ton_pkg::ST_DATA;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Next state and burst descriptor for the byte on the input.
    always_comb begin
        state_next = ton_pkg::ST_DATA;
        has_job    = 1'b0;
        job.kind   = ton_pkg::JOB_DATA;
        job.verb   = rx_byte;
        job.opt    = rx_byte;
        job.flag   = 1'b0;
        case (state_reg)
            ton_pkg::ST_IAC: begin
                case (rx_byte)
                    ton_pkg::C_DO:   state_next = ton_pkg::ST_DO;
                    ton_pkg::C_DONT: state_next = ton_pkg::ST_DONT;
                    ton_pkg::C_WILL: state_next = ton_pkg::ST_WILL;
                    ton_pkg::C_WONT: state_next = ton_pkg::ST_WONT;
                    ton_pkg::C_SB:   state_next = ton_pkg::ST_SBSTART;
                    ton_pkg::C_IAC: begin
                        // Escaped 0xFF goes to the terminal as data.
                        has_job  = 1'b1;
                        job.verb = ton_pkg::C_IAC;
                    end
                    default: state_next = ton_pkg::ST_DATA;
                endcase
            end
            ton_pkg::ST_DO: begin
                has_job  = 1'b1;
                job.kind = ton_pkg::JOB_REPLY3;
                if (rx_byte inside {ton_pkg::OPT_TTYPE, ton_pkg::OPT_NAWS}) begin
                    job.verb = ton_pkg::C_WILL;
                end else begin
                    job.verb = ton_pkg::C_WONT;
                end
                job.flag = (rx_byte == ton_pkg::OPT_NAWS);
            end
            ton_pkg::ST_DONT, ton_pkg::ST_WONT: begin
                state_next = ton_pkg::ST_DATA;
            end
            ton_pkg::ST_WILL: begin
                has_job  = 1'b1;
                job.kind = ton_pkg::JOB_REPLY3;
                if (rx_byte inside {ton_pkg::OPT_SGA, ton_pkg::OPT_ECHO}) begin
                    job.verb = ton_pkg::C_DO;
                end else begin
                    job.verb = ton_pkg::C_DONT;
                end
            end
            ton_pkg::ST_SBSTART: begin
                if (rx_byte == ton_pkg::OPT_TTYPE) begin
                    state_next = ton_pkg::ST_SBTTYPE;
                end else if (rx_byte == ton_pkg::C_IAC) begin
                    state_next = ton_pkg::ST_SBIAC;
                end else begin
                    state_next = ton_pkg::ST_SBBODY;
                end
            end
            ton_pkg::ST_SBBODY: begin
                state_next = (rx_byte == ton_pkg::C_IAC) ? ton_pkg::ST_SBIAC
                                                         : ton_pkg::ST_SBBODY;
            end
            ton_pkg::ST_SBIAC: begin
                state_next = (rx_byte == ton_pkg::C_SE) ? ton_pkg::ST_DATA
                                                        : ton_pkg::ST_SBBODY;
            end
            ton_pkg::ST_SBTTYPE: begin
                state_next = ton_pkg::ST_SBBODY;
                if (rx_byte == ton_pkg::Q_SEND) begin
                    has_job  = 1'b1;
                    job.kind = ton_pkg::JOB_TTYPE;
                end
            end
            default: begin
                // Data state; unused codes behave the same way.
                if (rx_byte == ton_pkg::C_IAC) begin
                    state_next = ton_pkg::ST_IAC;
                end else begin
                    has_job = 1'b1;
                end
            end
        endcase
    end

    assign job_load = accept && has_job;

endmodule

// ===== rtl/core/ton_emitter.sv =====
// ----------------------------------------------------------------------------
// Telnet result emitter
// Holds one burst descriptor and plays it out one item per cycle into the
// output register, under backpressure from the result channel.
// ----------------------------------------------------------------------------
module ton_emitter (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_load,
    input  ton_pkg::job_t job_in,
    output logic          job_ready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic [1:0]    m_tuser,
    output logic          m_tlast
);

    logic                      job_valid_reg;
    ton_pkg::job_t             job_reg;
    logic [ton_pkg::IDX_W-1:0] idx_reg;
    logic                      out_valid_reg;
    logic [7:0]                out_byte_reg;
    logic                      out_srv_reg;
    logic                      out_naws_reg;
    logic                      out_last_reg;

    logic                      out_free;
    logic                      advance;
    logic                      is_last;
    logic                      job_done;
    logic [7:0]                byte_next;
    logic                      srv_next;
    logic                      naws_next;

    // Handshake bookkeeping between the job slot and the output register.
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = job_valid_reg && out_free;
    assign job_done  = advance && is_last;
    assign job_ready = !job_valid_reg || job_done;

    // Select the byte at the current index of the burst.
    always_comb begin
        byte_next = job_reg.verb;
        srv_next  = 1'b1;
        naws_next = 1'b0;
        is_last   = 1'b1;
        case (job_reg.kind)
            ton_pkg::JOB_REPLY3: begin
                is_last = (idx_reg == ton_pkg::REPLY3_LAST);
                case (idx_reg)
                    4'd0: begin
                        byte_next = ton_pkg::C_IAC;
                        naws_next = job_reg.flag;
                    end
                    4'd1:    byte_next = job_reg.verb;
                    default: byte_next = job_reg.opt;
                endcase
            end
            ton_pkg::JOB_TTYPE: begin
                is_last   = (idx_reg == ton_pkg::TTYPE_LAST);
                byte_next = ton_pkg::ttype_byte(idx_reg);
            end
            default: begin
                srv_next = 1'b0;
                is_last  = (idx_reg == ton_pkg::DATA_LAST);
            end
        endcase
    end

    // Job slot and burst index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (job_load) begin
            job_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end else if (job_done) begin
            job_valid_reg <= 1'b0;
        end else if (advance) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Descriptor payload needs no reset.
    always_ff @(posedge aclk) begin
        if (job_load) begin
            job_reg <= job_in;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_byte_reg <= byte_next;
            out_srv_reg  <= srv_next;
            out_naws_reg <= naws_next;
            out_last_reg <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_naws_reg, out_srv_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/core/telnet_option_negotiator.sv =====
// ----------------------------------------------------------------------------
// Telnet option negotiator
// Tracks telnet option negotiation on received bytes and produces terminal
// data and reply bytes for the server.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel takes one received byte per item. The m_ channel gives
// result items: tdata is the byte, tuser[0] marks a reply to the server
// (clear for terminal data), tuser[1] marks the first byte of the WILL NAWS
// reply, and tlast marks the final item caused by one input byte.
// An accepted byte passes the sequencer slot and then the output register
// before its first result item. Data bytes and consumed command bytes go at
// one item per cycle while the receiver keeps up. A byte that causes a
// three-byte reply or a terminal-type SEND request holds the input until
// the single reply sequencer, one item per cycle unless stalled, is done.
// After reset the block is in the data state with no result pending.
// When the receiver stalls, the output register holds its item, the
// sequencer waits, and s_tready drops once the sequencer slot is occupied.
// ----------------------------------------------------------------------------
`include "telnet_option_negotiator_assert.svh"

module telnet_option_negotiator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] to_server, [1] naws_agreed
    output logic       m_tlast
);

    logic          s_accept;
    logic          job_load;
    logic          job_ready;
    ton_pkg::job_t job;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = job_ready;

    // Negotiation state and burst decode.
    ton_decoder u_decoder (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (s_accept),
        .rx_byte  (s_tdata),
        .job_load (job_load),
        .job      (job)
    );

    // Burst playout and output register.
    ton_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_load  (job_load),
        .job_in    (job),
        .job_ready (job_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // The NAWS flag only rides on the leading IAC of a server reply.
    `TON_ASSERT_SAME(a_naws_on_reply_iac, m_tvalid && m_tuser[1], m_tuser[0] && m_tdata == ton_pkg::C_IAC)

    // Terminal data is always a single-item result.
    `TON_ASSERT_SAME(a_data_single, m_tvalid && !m_tuser[0], m_tlast)

    // A reply burst continues without a gap once an inner item is taken.
    `TON_ASSERT_NEXT(a_burst_gapless, m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule

// ===== tb/tb_telnet_option_negotiator.sv =====
// ----------------------------------------------------------------------------
// Telnet option negotiator testbench
// Streams received telnet bytes into the negotiator and predicts every result
// item (terminal data, option replies and the terminal-type answer) from a
// private copy of the negotiation state. Each accepted result is matched in
// order against the prediction. The run starts with a short directed sequence
// and then goes through four phases of random exchanges with different
// sender and receiver idling, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_telnet_option_negotiator;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any accepted item before the run is declared hung.
    localparam int unsigned HANG_LIMIT = 2000;
    // Telnet NOP, a command that the negotiator drops.
    localparam logic [7:0] CMD_NOP = 8'd241;
    // Minimum number of received bytes per random phase.
    localparam int unsigned PHASE_ITEMS = 84;

    // One result item as it leaves the block.
    typedef struct packed {
        logic       to_server;
        logic [7:0] out_byte;
        logic       naws_agreed;
        logic       last;
    } neg_out_t;

    // Tracks the negotiation state and the result items still to come.
    class negotiation_tracker;
        ton_pkg::neg_state_t state;
        neg_out_t            pending_out[$];
        logic [7:0]          ttype_answer [11];
        int unsigned         faults;

        function new();
            state  = ton_pkg::ST_DATA;
            faults = 0;
            ttype_answer = '{ton_pkg::C_IAC, ton_pkg::C_SB, ton_pkg::OPT_TTYPE,
                             ton_pkg::Q_IS, 8'h76, 8'h74, 8'h31, 8'h30, 8'h30,
                             ton_pkg::C_IAC, ton_pkg::C_SE};
        endfunction

        function void emit(logic srv, logic [7:0] b, logic flag, logic tl);
            neg_out_t item;
            item.to_server   = srv;
            item.out_byte    = b;
            item.naws_agreed = flag;
            item.last        = tl;
            pending_out.push_back(item);
        endfunction

        // Three-byte reply: IAC, verb, option.
        function void answer3(logic [7:0] verb, logic [7:0] opt, logic flag);
            emit(1'b1, ton_pkg::C_IAC, flag, 1'b0);
            emit(1'b1, verb, 1'b0, 1'b0);
            emit(1'b1, opt, 1'b0, 1'b1);
        endfunction

        // Advance the negotiation by one received byte.
        function void take_rx_byte(logic [7:0] ch);
            ton_pkg::neg_state_t nx;
            nx = ton_pkg::ST_DATA;
            case (state)
                ton_pkg::ST_IAC: begin
                    if (ch == ton_pkg::C_DO) nx = ton_pkg::ST_DO;
                    else if (ch == ton_pkg::C_DONT) nx = ton_pkg::ST_DONT;
                    else if (ch == ton_pkg::C_WILL) nx = ton_pkg::ST_WILL;
                    else if (ch == ton_pkg::C_WONT) nx = ton_pkg::ST_WONT;
                    else if (ch == ton_pkg::C_SB) nx = ton_pkg::ST_SBSTART;
                    else if (ch == ton_pkg::C_IAC) emit(1'b0, ton_pkg::C_IAC, 1'b0, 1'b1);
                end
                ton_pkg::ST_DO: begin
                    if (ch == ton_pkg::OPT_TTYPE) answer3(ton_pkg::C_WILL, ch, 1'b0);
                    else if (ch == ton_pkg::OPT_NAWS) answer3(ton_pkg::C_WILL, ch, 1'b1);
                    else answer3(ton_pkg::C_WONT, ch, 1'b0);
                end
                ton_pkg::ST_DONT, ton_pkg::ST_WONT: ;
                ton_pkg::ST_WILL: begin
                    if (ch == ton_pkg::OPT_SGA || ch == ton_pkg::OPT_ECHO)
                        answer3(ton_pkg::C_DO, ch, 1'b0);
                    else
                        answer3(ton_pkg::C_DONT, ch, 1'b0);
                end
                ton_pkg::ST_SBSTART: begin
                    if (ch == ton_pkg::OPT_TTYPE) nx = ton_pkg::ST_SBTTYPE;
                    else if (ch == ton_pkg::C_IAC) nx = ton_pkg::ST_SBIAC;
                    else nx = ton_pkg::ST_SBBODY;
                end
                ton_pkg::ST_SBBODY:
                    nx = (ch == ton_pkg::C_IAC) ? ton_pkg::ST_SBIAC : ton_pkg::ST_SBBODY;
                ton_pkg::ST_SBIAC:
                    nx = (ch == ton_pkg::C_SE) ? ton_pkg::ST_DATA : ton_pkg::ST_SBBODY;
                ton_pkg::ST_SBTTYPE: begin
                    nx = ton_pkg::ST_SBBODY;
                    if (ch == ton_pkg::Q_SEND) begin
                        for (int i = 0; i < 11; i++)
                            emit(1'b1, ttype_answer[i], 1'b0, i == 10);
                    end
                end
                // Data state, and any code outside the defined states.
                default: begin
                    if (ch == ton_pkg::C_IAC) nx = ton_pkg::ST_IAC;
                    else emit(1'b0, ch, 1'b0, 1'b1);
                end
            endcase
            state = nx;
        endfunction

        // Compare one accepted result item with the oldest prediction.
        function void match_output(logic [7:0] data, logic [1:0] user, logic tl);
            neg_out_t want;
            if (pending_out.size() == 0) begin
                $error("result item with none expected: out_byte %02h", data);
                faults++;
                return;
            end
            want = pending_out.pop_front();
            if (user[0] !== want.to_server) begin
                $error("to_server mismatch: expected %0d, actual %0d",
                       want.to_server, user[0]);
                faults++;
            end
            if (data !== want.out_byte) begin
                $error("out_byte mismatch: expected %02h, actual %02h",
                       want.out_byte, data);
                faults++;
            end
            if (user[1] !== want.naws_agreed) begin
                $error("naws_agreed mismatch: expected %0d, actual %0d",
                       want.naws_agreed, user[1]);
                faults++;
            end
            if (tl !== want.last) begin
                $error("last mismatch: expected %0d, actual %0d", want.last, tl);
                faults++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_out.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    negotiation_tracker book = new();

    logic [7:0]  rx_stream[$];
    int unsigned send_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_len = 0;
    int unsigned quiet_cycles = 0;

    telnet_option_negotiator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 2 ns clock.
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                hold_len--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // Watch both channels, feed the tracker and guard against a hang.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                book.take_rx_byte(s_tdata);
            if (m_tvalid && m_tready)
                book.match_output(m_tdata, m_tuser, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic logic [7:0] pick_option();
        case ($urandom_range(0, 5))
            0:       return ton_pkg::OPT_TTYPE;
            1:       return ton_pkg::OPT_NAWS;
            2:       return ton_pkg::OPT_SGA;
            3:       return ton_pkg::OPT_ECHO;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Append one exchange: mostly well-formed commands with random content,
    // some plain data, and some noise that breaks sequences.
    function automatic void add_exchange();
        int unsigned pick;
        int unsigned body_len;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            rx_stream.push_back(8'($urandom_range(0, 254)));
        end else if (pick < 30) begin
            rx_stream.push_back(ton_pkg::C_IAC);
            rx_stream.push_back(ton_pkg::C_IAC);
        end else if (pick < 60) begin
            rx_stream.push_back(ton_pkg::C_IAC);
            case ($urandom_range(0, 3))
                0:       rx_stream.push_back(ton_pkg::C_DO);
                1:       rx_stream.push_back(ton_pkg::C_DONT);
                2:       rx_stream.push_back(ton_pkg::C_WILL);
                default: rx_stream.push_back(ton_pkg::C_WONT);
            endcase
            rx_stream.push_back(pick_option());
        end else if (pick < 65) begin
            // IAC with any command byte, known or not.
            rx_stream.push_back(ton_pkg::C_IAC);
            rx_stream.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 75) begin
            rx_stream.push_back(ton_pkg::C_IAC);
            rx_stream.push_back(ton_pkg::C_SB);
            rx_stream.push_back(ton_pkg::OPT_TTYPE);
            rx_stream.push_back(ton_pkg::Q_SEND);
            rx_stream.push_back(ton_pkg::C_IAC);
            rx_stream.push_back(ton_pkg::C_SE);
        end else if (pick < 90) begin
            // Subnegotiation with a random option and body, doubled IAC inside.
            rx_stream.push_back(ton_pkg::C_IAC);
            rx_stream.push_back(ton_pkg::C_SB);
            rx_stream.push_back(pick < 80 ? ton_pkg::OPT_TTYPE
                                          : 8'($urandom_range(0, 255)));
            body_len = $urandom_range(0, 4);
            for (int i = 0; i < body_len; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    rx_stream.push_back(ton_pkg::C_IAC);
                    rx_stream.push_back(ton_pkg::C_IAC);
                end else begin
                    rx_stream.push_back(8'($urandom_range(0, 254)));
                end
            end
            rx_stream.push_back(ton_pkg::C_IAC);
            rx_stream.push_back(ton_pkg::C_SE);
        end else begin
            rx_stream.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // Offer one byte, with random idle cycles ahead of it.
    task automatic offer_byte(input logic [7:0] b);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic play_stream();
        while (rx_stream.size() != 0)
            offer_byte(rx_stream.pop_front());
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: data extremes (a command code as plain data), doubled
        // IAC, DO TTYPE, DO NAWS, WILL ECHO, DONT, a dropped command and a
        // terminal-type SEND request.
        rx_stream = '{8'h00, ton_pkg::C_DONT, ton_pkg::C_IAC, ton_pkg::C_IAC,
                      ton_pkg::C_IAC, ton_pkg::C_DO, ton_pkg::OPT_TTYPE,
                      ton_pkg::C_IAC, ton_pkg::C_DO, ton_pkg::OPT_NAWS,
                      ton_pkg::C_IAC, ton_pkg::C_WILL, ton_pkg::OPT_ECHO,
                      ton_pkg::C_IAC, ton_pkg::C_DONT, ton_pkg::OPT_SGA,
                      ton_pkg::C_IAC, CMD_NOP,
                      ton_pkg::C_IAC, ton_pkg::C_SB, ton_pkg::OPT_TTYPE,
                      ton_pkg::Q_SEND, ton_pkg::C_IAC, ton_pkg::C_SE};
        play_stream();

        // Random phases with different idling on either side.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 0;
                    // Long receiver hold-off so that the block backs up.
                    hold_len = 80;
                end
                1: begin
                    send_idle_pct  = 52;
                    sink_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 52;
                end
                default: begin
                    send_idle_pct  = 24;
                    sink_stall_pct = 24;
                end
            endcase
            while (rx_stream.size() < PHASE_ITEMS)
                add_exchange();
            play_stream();
        end
        s_tvalid <= 1'b0;

        // Let the monitor note the last accepted byte, drain the remaining
        // results, then allow for stray items.
        @(posedge aclk);
        while (book.outstanding() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (book.faults == 0 && book.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ton_pkg.sv
rtl/core/ton_decoder.sv
rtl/core/ton_emitter.sv
rtl/core/telnet_option_negotiator.sv
tb/tb_telnet_option_negotiator.sv
